/* rtl/htsf_pkg.sv */
// shared types and character codes for the markup-stripping byte filter
package htsf_pkg;

  localparam int unsigned ChW    = 8;
  localparam int unsigned MarkW  = 3;
  localparam int unsigned DepthW = 8;

  localparam logic [ChW-1:0] ChNul   = 8'h00;
  localparam logic [ChW-1:0] ChLt    = 8'h3C;
  localparam logic [ChW-1:0] ChGt    = 8'h3E;
  localparam logic [ChW-1:0] ChOpen  = 8'h28;
  localparam logic [ChW-1:0] ChClose = 8'h29;
  localparam logic [ChW-1:0] ChQuest = 8'h3F;
  localparam logic [ChW-1:0] ChQuote = 8'h22;

  localparam logic [MarkW-1:0] MarkNone  = 3'd0;
  localparam logic [MarkW-1:0] MarkLt    = 3'd1;
  localparam logic [MarkW-1:0] MarkOpen  = 3'd2;
  localparam logic [MarkW-1:0] MarkClose = 3'd3;
  localparam logic [MarkW-1:0] MarkGt    = 3'd4;
  localparam logic [MarkW-1:0] MarkQuote = 3'd5;

  localparam logic signed [DepthW-1:0] DepthMax = 8'sd127;
  localparam logic signed [DepthW-1:0] DepthMin = -8'sd127;

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           line_start;
    logic           new_file;
  } req_t;

endpackage

/* rtl/htsf_core.sv */
// markup tracking state and per-byte pass or drop decision
module htsf_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  htsf_pkg::req_t req_i,
  output logic          emit_o
);
  import htsf_pkg::*;

  typedef enum logic [1:0] {
    MODE_TEXT  = 2'd0,
    MODE_TAG   = 2'd1,
    MODE_INSTR = 2'd2
  } mode_e;

  mode_e                     mode_q, mode_d, mode_cur;
  logic [MarkW-1:0]          mark_q, mark_d, mark_cur;
  logic signed [DepthW-1:0]  depth_q, depth_d, depth_cur;
  logic                      quoted;
  logic                      emit;

  always_comb begin
    mode_cur  = req_i.new_file ? MODE_TEXT : mode_q;
    mark_cur  = req_i.line_start ? MarkNone : mark_q;
    depth_cur = req_i.line_start ? '0 : depth_q;
    quoted    = (mark_cur == MarkQuote);
    mode_d    = mode_cur;
    mark_d    = mark_cur;
    depth_d   = depth_cur;
    emit      = 1'b0;
    if (req_i.ch != ChNul) begin
      case (mode_cur)
        MODE_TEXT: begin
          if (req_i.ch == ChLt) begin
            mark_d = MarkLt;
            mode_d = MODE_TAG;
          end else if (req_i.ch != ChGt) begin
            emit = 1'b1;
          end
        end
        MODE_TAG: begin
          if (req_i.ch == ChGt) begin
            mark_d = MarkGt;
            mode_d = MODE_TEXT;
          end else if (req_i.ch == ChQuest) begin
            depth_d = '0;
            mode_d  = MODE_INSTR;
          end
        end
        MODE_INSTR: begin
          if (req_i.ch == ChQuote) begin
            mark_d = quoted ? MarkNone : MarkQuote;
          end else if (req_i.ch == ChOpen && !quoted) begin
            mark_d = MarkOpen;
            if (depth_cur != DepthMax) depth_d = depth_cur + 8'sd1;
          end else if (req_i.ch == ChClose && !quoted) begin
            mark_d = MarkClose;
            if (depth_cur != DepthMin) depth_d = depth_cur - 8'sd1;
          end else if (req_i.ch == ChGt && !quoted && depth_cur == '0) begin
            mode_d = MODE_TEXT;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  assign emit_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_TEXT;
      mark_q  <= MarkNone;
      depth_q <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      mark_q  <= mark_d;
      depth_q <= depth_d;
    end
  end

  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q != -8'sd128)
    else $error("paren depth out of range");

  a_nul_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.ch == ChNul) |-> !emit_o)
    else $error("zero byte emitted");

  a_markup_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_TEXT && !req_i.new_file) |-> !emit_o)
    else $error("byte emitted inside markup");

  a_nul_holds_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && req_i.ch == ChNul && !req_i.new_file) |=> $stable(mode_q))
    else $error("zero byte changed mode");

endmodule

/* rtl/html_tag_strip_filter_unit.sv */
// markup-stripping byte filter top level with input and result registers
// Takes one text byte per cycle, unless stalled, and forwards it only while
// outside tags and instruction blocks. A request is registered on entry, the
// markup state (mode, quote mark, parenthesis depth) is updated from that
// register, and a passed byte lands in the result register, so a byte reaches
// the output through the request and result registers. Sustained rate is one
// byte per cycle; a stalled result only holds back a byte that would itself be
// emitted.
module html_tag_strip_filter_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [htsf_pkg::ChW-1:0]  ch_i,
  input  logic                      line_start_i,
  input  logic                      new_file_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [htsf_pkg::ChW-1:0]  out_ch_o
);
  import htsf_pkg::*;

  logic           in_valid_q;
  req_t           req_q;
  logic           out_valid_q;
  logic [ChW-1:0] out_ch_q;
  logic           emit;
  logic           advance;
  logic           step;

  assign advance    = !out_valid_q || !out_stall_i || !emit;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  htsf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (req_q),
    .emit_o (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q.ch         <= ch_i;
      req_q.line_start <= line_start_i;
      req_q.new_file   <= new_file_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_ch_q <= req_q.ch;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_ch_o    = out_ch_q;

endmodule

/* tb/sv/tb_html_tag_strip_filter_unit.sv */
// self-checking testbench for the markup-stripping byte filter with random stall and idle
module tb_html_tag_strip_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import htsf_pkg::*;

  typedef enum logic [1:0] {
    ModeText  = 2'd0,
    ModeTag   = 2'd1,
    ModeInstr = 2'd2
  } strip_mode_e;

  typedef struct {
    req_t req;
    bit   drain;
  } queued_req_t;

  localparam int unsigned RandomBytes = 600;
  localparam int unsigned LongHold    = 120;

  logic           clk_i        = 1'b0;
  logic           rst_ni       = 1'b0;
  logic           in_valid_i   = 1'b0;
  logic           in_stall_o;
  logic [ChW-1:0] ch_i         = ChNul;
  logic           line_start_i = 1'b0;
  logic           new_file_i   = 1'b0;
  logic           out_valid_o;
  logic           out_stall_i  = 1'b1;
  logic [ChW-1:0] out_ch_o;

  queued_req_t         byte_requests[$];
  logic [ChW-1:0]      passed_bytes[$];
  strip_mode_e         cur_mode  = ModeText;
  logic [MarkW-1:0]    cur_mark  = MarkNone;
  logic signed [DepthW-1:0] cur_depth = '0;
  int                  err_count = 0;
  int                  result_count = 0;
  int                  tx_idle = 0;
  int                  tx_burst = 0;
  int                  rx_idle = 0;
  int                  rx_burst = 0;
  int                  rx_hold = 0;
  bit                  line_pend = 1'b0;
  bit                  file_pend = 1'b0;
  bit                  drain_pend = 1'b0;

  html_tag_strip_filter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .line_start_i(line_start_i),
    .new_file_i  (new_file_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_ch_o    (out_ch_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // expected output of one accepted byte
  function automatic void strip_markup(input req_t r);
    bit emit;
    emit = 1'b0;
    if (r.new_file) cur_mode = ModeText;
    if (r.line_start) begin
      cur_mark  = MarkNone;
      cur_depth = '0;
    end
    if (r.ch != ChNul) begin
      case (r.ch)
        ChLt: begin
          if (cur_mode == ModeText) begin
            cur_mark = MarkLt;
            cur_mode = ModeTag;
          end
        end
        ChOpen: begin
          if (cur_mode == ModeInstr) begin
            if (cur_mark != MarkQuote) begin
              cur_mark = MarkOpen;
              if (cur_depth < DepthMax) cur_depth = cur_depth + 8'sd1;
            end
          end else if (cur_mode == ModeText) begin
            emit = 1'b1;
          end
        end
        ChClose: begin
          if (cur_mode == ModeInstr) begin
            if (cur_mark != MarkQuote) begin
              cur_mark = MarkClose;
              if (cur_depth > DepthMin) cur_depth = cur_depth - 8'sd1;
            end
          end else if (cur_mode == ModeText) begin
            emit = 1'b1;
          end
        end
        ChGt: begin
          if (cur_mode == ModeTag) begin
            cur_mark = MarkGt;
            cur_mode = ModeText;
          end else if (cur_mode == ModeInstr) begin
            if (cur_depth == 0 && cur_mark != MarkQuote) cur_mode = ModeText;
          end
        end
        ChQuote: begin
          if (cur_mode == ModeInstr) begin
            cur_mark = (cur_mark == MarkQuote) ? MarkNone : MarkQuote;
          end else if (cur_mode == ModeText) begin
            emit = 1'b1;
          end
        end
        ChQuest: begin
          if (cur_mode == ModeTag) begin
            cur_depth = '0;
            cur_mode  = ModeInstr;
          end else if (cur_mode == ModeText) begin
            emit = 1'b1;
          end
        end
        default: begin
          if (cur_mode == ModeText) emit = 1'b1;
        end
      endcase
    end
    if (emit) passed_bytes.push_back(r.ch);
  endfunction

  function automatic int draw_gap(inout int burst);
    int roll;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst = $urandom_range(30, 80);
      return 0;
    end
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      ch_i         <= ChNul;
      line_start_i <= 1'b0;
      new_file_i   <= 1'b0;
      tx_idle = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        strip_markup('{ch: ch_i, line_start: line_start_i, new_file: new_file_i});
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_idle > 0) begin
          tx_idle--;
          in_valid_i <= 1'b0;
        end else if (byte_requests.size() > 0 &&
                     !(byte_requests[0].drain && passed_bytes.size() > 0)) begin
          ch_i         <= byte_requests[0].req.ch;
          line_start_i <= byte_requests[0].req.line_start;
          new_file_i   <= byte_requests[0].req.new_file;
          in_valid_i   <= 1'b1;
          void'(byte_requests.pop_front());
          tx_idle = draw_gap(tx_burst);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    logic [ChW-1:0] want;
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
      rx_idle = 0;
      rx_hold = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (passed_bytes.size() == 0) begin
          $error("out_ch: no byte expected, got %h", out_ch_o);
          err_count++;
        end else begin
          want = passed_bytes.pop_front();
          if (out_ch_o !== want) begin
            $error("out_ch: expected %h, got %h", want, out_ch_o);
            err_count++;
          end
        end
        result_count++;
        if (result_count == 60 || result_count == 500) rx_hold = LongHold;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall_i <= 1'b1;
      end else if (rx_idle > 0) begin
        rx_idle--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        rx_idle = draw_gap(rx_burst);
      end
    end
  end

  task automatic add_byte(input logic [ChW-1:0] c);
    queued_req_t q;
    q.req.ch         = c;
    q.req.line_start = line_pend;
    q.req.new_file   = file_pend;
    q.drain          = drain_pend;
    line_pend  = 1'b0;
    file_pend  = 1'b0;
    drain_pend = 1'b0;
    byte_requests.push_back(q);
  endtask

  task automatic add_run(input logic [ChW-1:0] c, input int n);
    repeat (n) add_byte(c);
  endtask

  task automatic start_line();
    line_pend = 1'b1;
    if ($urandom_range(0, 19) == 0) file_pend = 1'b1;
  endtask

  function automatic logic [ChW-1:0] text_byte();
    logic [ChW-1:0] c;
    do c = ChW'($urandom_range(32, 126)); while (c == ChLt);
    return c;
  endfunction

  function automatic logic [ChW-1:0] letter();
    return ChW'($urandom_range(8'h61, 8'h7A));
  endfunction

  task automatic add_tag();
    int n;
    add_byte(ChLt);
    n = $urandom_range(0, 6);
    repeat (n) add_byte(letter());
    if ($urandom_range(0, 9) != 0) add_byte(ChGt);
  endtask

  task automatic add_instruction();
    int depth;
    int n;
    int m;
    add_byte(ChLt);
    add_byte(ChQuest);
    depth = 0;
    n = $urandom_range(2, 14);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          add_byte(ChOpen);
          depth++;
        end
        2: begin
          if (depth > 0) begin
            add_byte(ChClose);
            depth--;
          end
        end
        3: begin
          add_byte(ChQuote);
          m = $urandom_range(0, 4);
          repeat (m) begin
            case ($urandom_range(0, 3))
              0: add_byte(letter());
              1: add_byte(ChOpen);
              2: add_byte(ChClose);
              default: add_byte(ChGt);
            endcase
          end
          add_byte(ChQuote);
        end
        4: begin
          if (depth > 0) add_byte(ChGt);
        end
        5: begin
          if ($urandom_range(0, 3) == 0) begin
            start_line();
            depth = 0;
          end
        end
        default: add_byte(letter());
      endcase
    end
    while (depth > 0) begin
      add_byte(ChClose);
      depth--;
    end
    if ($urandom_range(0, 9) != 0) add_byte(ChGt);
  endtask

  initial begin
    #3_000_000;
    $display("tb_html_tag_strip_filter_unit: errors");
    $finish;
  end

  initial begin
    int target;
    int n;
    bit mid_drain;
    // directed requests
    file_pend = 1'b1;
    line_pend = 1'b1;
    add_byte(8'h41);
    add_byte(8'hFF);
    add_byte(ChNul);
    add_byte(ChOpen);
    add_byte(ChClose);
    add_byte(ChQuote);
    add_byte(ChQuest);
    add_byte(ChGt);
    add_byte(ChLt);
    add_byte(8'h78);
    add_byte(ChOpen);
    add_byte(ChLt);
    add_byte(ChQuote);
    add_byte(ChQuest);
    add_byte(ChOpen);
    add_byte(ChQuote);
    add_byte(ChClose);
    add_byte(ChGt);
    add_byte(ChQuote);
    add_byte(ChGt);
    add_byte(ChClose);
    add_byte(ChGt);
    add_byte(8'h62);
    // zero byte still clears the quote mark at line start
    add_byte(ChLt);
    add_byte(ChQuest);
    add_byte(ChQuote);
    line_pend = 1'b1;
    add_byte(ChNul);
    add_byte(ChGt);
    // new file leaves an instruction
    add_byte(ChLt);
    add_byte(ChQuest);
    file_pend = 1'b1;
    add_byte(8'h71);
    // depth saturation both ways
    add_byte(ChLt);
    add_byte(ChQuest);
    add_run(ChOpen, 130);
    add_byte(ChGt);
    line_pend = 1'b1;
    add_byte(ChNul);
    add_byte(ChGt);
    add_byte(ChLt);
    add_byte(ChQuest);
    add_run(ChClose, 130);
    add_byte(ChGt);
    line_pend = 1'b1;
    add_byte(8'h61);
    add_byte(ChGt);
    add_byte(8'h7A);
    add_byte(ChLt);
    file_pend = 1'b1;
    add_byte(ChNul);
    add_byte(8'h63);

    // random lines, mostly well-formed markup
    target    = byte_requests.size() + RandomBytes;
    mid_drain = 1'b0;
    drain_pend = 1'b1;
    while (byte_requests.size() < target) begin
      if (!mid_drain && byte_requests.size() > target - RandomBytes / 2) begin
        drain_pend = 1'b1;
        mid_drain  = 1'b1;
      end
      start_line();
      if ($urandom_range(0, 32) == 0) add_byte(ChNul);
      n = $urandom_range(1, 5);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            repeat ($urandom_range(1, 10)) begin
              if ($urandom_range(0, 19) == 0) add_byte(ChGt);
              else add_byte(text_byte());
            end
          end
          5, 6: add_tag();
          7, 8: add_instruction();
          default: begin
            repeat ($urandom_range(1, 6)) add_byte(ChW'($urandom_range(0, 255)));
          end
        endcase
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_requests.size() > 0 || in_valid_i || passed_bytes.size() > 0)
      @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (err_count == 0 && passed_bytes.size() == 0) begin
      $display("tb_html_tag_strip_filter_unit: clean");
    end else begin
      $display("tb_html_tag_strip_filter_unit: errors");
    end
    $finish;
  end

endmodule
